// ===== sv/lfo_md_pkg.sv =====
// Package for the stereo modulated delay: payload types, register indexes,
// fixed-point helpers. No dependencies.
`default_nettype none
package lfo_md_pkg;

    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_MIN_DELAY  = 3'd0,
        REG_MAX_DELAY  = 3'd1,
        REG_PHASE_STEP = 3'd2,
        REG_FEEDBACK   = 3'd3,
        REG_WET        = 3'd4,
        REG_SMOOTH_B0  = 3'd5,
        REG_SMOOTH_A1  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [19:0]        min_delay;
        logic [19:0]        max_delay;
        logic [23:0]        phase_step;
        logic signed [15:0] feedback_gain;
        logic [16:0]        wet_gain;
        logic [24:0]        smooth_gain;
        logic signed [25:0] smooth_pole;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SINE, ST_LFO, ST_SMB, ST_SMF, ST_SMA, ST_SMV,
        ST_RD0, ST_RD1, ST_WET, ST_MIXA, ST_MIXB, ST_DONE
    } lane_state_t;

    localparam logic [31:0] PHASE_START = 32'd683565276;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

    // Sine in Q1.23 of a phase in turns * 2^32; used for the constant table.
    // The peak can reach +1.0, so the result carries one extra bit.
    function automatic logic signed [24:0] sine_of_turn(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int divs [5];
        divs = '{110, 72, 42, 20, 6};
        r = {34'd0, p[29:0]};
        if (p[30])
            r = {33'd0, ONE_Q30} - r;
        x = (r * {32'd0, HALF_PI_Q30}) >> 30;
        x2 = (x * x) >> 30;
        t = {33'd0, ONE_Q30};
        for (int i = 0; i < 5; i++)
            t = {33'd0, ONE_Q30} - ((x2 * t) >> 30) / 64'(divs[i]);
        s = (((x * t) >> 30) + 64'd64) >> 7;
        if (p[31])
            return -(s[24:0]);
        return s[24:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/lfo_md_lane.sv =====
// One processing lane: LFO, delay smoother, allpass read, feedback write, mix.
// Depends on lfo_md_pkg. Holds its own delay-line memory.
`default_nettype none
module lfo_md_lane #(
    parameter int DELAY_DEPTH     = 8192,
    parameter int SINE_TABLE_SIZE = 1024,
    parameter logic [31:0] PHASE_INIT = 32'd683565276
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [23:0]            sample,
    input  wire lfo_md_pkg::cfg_t              cfg,
    input  wire logic [$clog2(DELAY_DEPTH)-1:0] windex,
    output logic                               done,
    output logic signed [23:0]                 result
);
    import lfo_md_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int TW = $clog2(SINE_TABLE_SIZE);

    logic signed [24:0] sine_rom [SINE_TABLE_SIZE];
    always_comb
    begin
        for (int i = 0; i < SINE_TABLE_SIZE; i++)
            sine_rom[i] = sine_of_turn(32'((64'(i) << 32) / SINE_TABLE_SIZE));
    end

    logic signed [23:0] mem [DELAY_DEPTH];

    lane_state_t state_reg, state_next;
    logic [31:0]        phase_reg;
    logic signed [39:0] v1_reg;
    logic signed [23:0] yold_reg;
    logic [AW:0]        clr_reg;
    logic signed [24:0] sin_reg;
    logic signed [47:0] lfo_reg;
    logic signed [47:0] bl_reg;
    logic signed [31:0] f_reg;
    logic signed [63:0] af_reg;
    logic [AW-1:0]      i0_reg;
    logic signed [23:0] x0_reg;
    logic signed [23:0] rd_reg;
    logic signed [23:0] y_reg;
    logic signed [63:0] mix_reg;
    logic signed [23:0] in_reg;
    logic [AW-1:0]      wi_reg;

    logic               clearing;
    assign clearing = !clr_reg[AW];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start && !clearing) state_next = ST_SINE;
            ST_SINE: state_next = ST_LFO;
            ST_LFO:  state_next = ST_SMB;
            ST_SMB:  state_next = ST_SMF;
            ST_SMF:  state_next = ST_SMA;
            ST_SMA:  state_next = ST_SMV;
            ST_SMV:  state_next = ST_RD0;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_WET;
            ST_WET:  state_next = ST_MIXA;
            ST_MIXA: state_next = ST_MIXB;
            ST_MIXB: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == ST_DONE);
    end

    // datapath helpers
    logic signed [21:0] span;
    logic signed [47:0] prod_lfo;
    logic signed [47:0] bsum;
    logic signed [17:0] a_coef;
    logic signed [24:0] diff;
    logic signed [63:0] wsum;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [23:0] mem_wd;
    logic signed [47:0] ybl;
    logic signed [39:0] fbp;

    always_comb
    begin
        span = $signed({2'b0, cfg.max_delay}) - $signed({2'b0, cfg.min_delay});
        prod_lfo = 48'(span) * 48'(26'(sin_reg) + 26'sd8388608);
        bsum = bl_reg + 48'(v1_reg);
        a_coef = 18'sd65536 - $signed({2'b0, f_reg[15:0]});
        diff = 25'(x0_reg) - 25'(yold_reg);
        ybl = 48'(mix_reg) >>> 16;
        rd_addr = (state_reg == ST_SMV) ? 
                  AW'(windex + f_reg[16 +: AW]) : AW'(i0_reg + 1'b1);
        fbp = 40'(y_reg) * 40'(cfg.feedback_gain);
        wsum = 64'(y_reg) * 64'($signed({1'b0, cfg.wet_gain}))
             + 64'(in_reg) * (64'sd65536 - 64'($signed({1'b0, cfg.wet_gain})));
        mem_we = clearing || (state_reg == ST_MIXA);
        mem_wa = clearing ? clr_reg[AW-1:0] : wi_reg;
        mem_wd = clearing ? 24'sd0 : sat24(64'(in_reg) - 64'(fbp >>> 15));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[rd_addr];
    end

    function automatic logic signed [39:0] sat_v(input logic signed [63:0] v);
        if (v > 64'sh7F_FFFF_FFFF)
            return 40'sh7F_FFFF_FFFF;
        else if (v < -64'sh80_0000_0000)
            return 40'sh80_0000_0000;
        return v[39:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PHASE_INIT;
            v1_reg    <= '0;
            yold_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE && start && !clearing)
                phase_reg <= phase_reg + {8'd0, cfg.phase_step};
            if (state_reg == ST_SMV)
                v1_reg <= 40'(sat_v(64'(bl_reg) - (af_reg >>> 24)));
            // y_reg holds this frame's wet sample from here on
            if (state_reg == ST_MIXA)
                yold_reg <= y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                in_reg <= sample;
                wi_reg <= windex;
            end
            ST_SINE: sin_reg <= sine_rom[phase_reg[31 -: TW]];
            ST_LFO:  lfo_reg <= (prod_lfo >>> 24) + 48'($signed({1'b0, cfg.min_delay}))
                                + 48'sd256;
            ST_SMB:  bl_reg <= 48'((64'(lfo_reg) * 64'($signed({1'b0, cfg.smooth_gain})))
                               >>> 16);
            ST_SMF:  f_reg <= (bsum > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                              (bsum < -48'sh8000_0000) ? 32'sh8000_0000 : bsum[31:0];
            ST_SMA:  af_reg <= 64'(f_reg) * 64'(cfg.smooth_pole);
            ST_SMV:  i0_reg <= rd_addr;
            ST_RD0:  x0_reg <= rd_reg;
            ST_RD1:  ;
            ST_WET:
            begin
                y_reg <= sat24((64'(42'(a_coef) * 42'(diff)) >>> 16) + 64'(rd_reg));
            end
            ST_MIXA: mix_reg <= wsum;
            ST_MIXB: result <= sat24(64'(ybl));
            default: ;
        endcase
    end

    // Read pointer follows i0+1 on the second read
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> state_reg == ST_IDLE) else $error("lane busy during clear");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done not a pulse");
    a_start_go: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && !clearing) |=> state_reg == ST_SINE)
        else $error("lane failed to start");
endmodule
`default_nettype wire

// ===== sv/lfo_modulated_delay.sv =====
// Stereo LFO-modulated delay (chorus / flanger), top level with merge stage.
// One frame at a time: a new frame is taken only once the lane sequencer has
// finished the last one and the output register is empty.
// After reset each lane clears its delay line, during which no input is
// taken; configuration writes are taken at any time.
// Depends on lfo_md_pkg and lfo_md_lane.
`default_nettype none
module lfo_modulated_delay #(
    parameter int DELAY_DEPTH     = 8192,
    parameter int SINE_TABLE_SIZE = 1024,
    parameter int LANES           = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lfo_md_pkg::in_item_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lfo_md_pkg::out_item_t      out_data,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [25:0]           cfg_data
);
    import lfo_md_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);

    cfg_t cfg_reg;
    logic [AW-1:0] windex_reg;
    logic busy_reg;
    logic [LANES-1:0] done_v;
    logic signed [23:0] res_v [LANES];
    logic signed [23:0] sample_v [LANES];
    logic start;

    // Accept a frame only when idle and the output register is empty,
    // so a waiting result never gets overwritten.
    assign start = in_valid && in_ready;

    always_comb
    begin
        sample_v[0] = in_data.left_in;
        if (LANES > 1)
            sample_v[LANES-1] = in_data.right_in;
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            lfo_md_lane #(
                .DELAY_DEPTH(DELAY_DEPTH),
                .SINE_TABLE_SIZE(SINE_TABLE_SIZE),
                .PHASE_INIT(PHASE_START + (g == 1 ? QUARTER_TURN : 32'd0))
            ) u_lane (
                .clk(clk), .rst_n(rst_n), .start(start), .sample(sample_v[g]),
                .cfg(cfg_reg), .windex(windex_reg),
                .done(done_v[g]), .result(res_v[g])
            );
        end
    endgenerate

    // Lanes run in lockstep; a lane still clearing keeps in_ready low.
    logic lanes_ready;
    assign lanes_ready = (g_lane[0].u_lane.clr_reg[AW] == 1'b1);
    assign in_ready = !busy_reg && !out_valid && lanes_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            out_valid  <= 1'b0;
            windex_reg <= AW'(DELAY_DEPTH - 1);
            cfg_reg.min_delay     <= 20'd86016;
            cfg_reg.max_delay     <= 20'd245760;
            cfg_reg.phase_step    <= 24'd49169;
            cfg_reg.feedback_gain <= '0;
            cfg_reg.wet_gain      <= 17'd32768;
            cfg_reg.smooth_gain   <= 25'd43806;
            cfg_reg.smooth_pole   <= -26'sd16689606;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            // Merge: collect lane results, advance write index.
            if (done_v[0])
            begin
                busy_reg  <= 1'b0;
                out_valid <= 1'b1;
                windex_reg <= (windex_reg == '0) ? AW'(DELAY_DEPTH - 1) : windex_reg - 1'b1;
            end
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_DELAY:  cfg_reg.min_delay     <= cfg_data[19:0];
                    REG_MAX_DELAY:  cfg_reg.max_delay     <= cfg_data[19:0];
                    REG_PHASE_STEP: cfg_reg.phase_step    <= cfg_data[23:0];
                    REG_FEEDBACK:   cfg_reg.feedback_gain <= cfg_data[15:0];
                    REG_WET:        cfg_reg.wet_gain      <= cfg_data[16:0];
                    REG_SMOOTH_B0:  cfg_reg.smooth_gain   <= cfg_data[24:0];
                    REG_SMOOTH_A1:  cfg_reg.smooth_pole   <= cfg_data[25:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_v[0])
        begin
            out_data.left_out  <= res_v[0];
            out_data.right_out <= (LANES > 1) ? res_v[LANES-1] : 24'sd0;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done_v[0] |-> !out_valid) else $error("result overwritten");
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_v[0] == done_v[LANES-1]) else $error("lanes out of step");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("frame lost");
endmodule
`default_nettype wire

// ===== tb/lfo_modulated_delay_checker.sv =====
// Checker for the stereo modulated delay: watches the frame and config ports,
// predicts every output frame and compares it. Depends on lfo_md_pkg.
`default_nettype none
module lfo_modulated_delay_checker #(
    parameter int DELAY_DEPTH     = 8192,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire lfo_md_pkg::in_item_t  in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire lfo_md_pkg::out_item_t out_data,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [25:0]           cfg_data,
    output int                         fail_count,
    output int                         pending_frames,
    output int                         checked_frames
);
    import lfo_md_pkg::*;

    localparam longint ONE_Q30_L = 64'd1073741824;
    localparam longint HALF_PI_L = 64'd1686629713;

    logic signed [24:0] sine_lut [SINE_TABLE_SIZE];
    logic signed [23:0] line_mem [2][DELAY_DEPTH];
    longint             smooth_mem [2];
    longint             last_wet [2];
    logic [31:0]        phase_acc [2];
    int                 wr_ptr;
    cfg_t               knobs;
    out_item_t          mix_queue [$];

    function automatic longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Quarter-wave Taylor evaluation, integer only; the peak may reach +1.0.
    function automatic logic signed [24:0] taylor_sine(logic [31:0] p);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int          dv [5];
        dv = '{110, 72, 42, 20, 6};
        r = {34'd0, p[29:0]};
        if (p[30])
            r = ONE_Q30_L - r;
        x = (r * HALF_PI_L) >> 30;
        x2 = (x * x) >> 30;
        t = ONE_Q30_L;
        for (int i = 0; i < 5; i++)
            t = ONE_Q30_L - ((x2 * t) >> 30) / dv[i];
        s = (((x * t) >> 30) + 64'd64) >> 7;
        return p[31] ? -$signed(s[24:0]) : $signed(s[24:0]);
    endfunction

    function automatic longint lane_sample(int ln, longint smp);
        longint u;
        longint span;
        longint lfo;
        longint bl;
        longint f;
        longint k;
        longint frac;
        longint km;
        longint x0;
        longint x1;
        longint y;
        longint wet;
        int     i0;
        int     i1;
        int     ti;
        phase_acc[ln] = phase_acc[ln] + 32'(knobs.phase_step);
        ti = int'((64'(phase_acc[ln]) * SINE_TABLE_SIZE) >> 32);
        u = longint'(sine_lut[ti]) + 8388608;
        span = longint'(knobs.max_delay) - longint'(knobs.min_delay);
        lfo = fshr(span * u, 24) + longint'(knobs.min_delay) + 256;
        bl = fshr(longint'(knobs.smooth_gain) * lfo, 16);
        f = clip(bl + smooth_mem[ln], 32);
        smooth_mem[ln] = clip(bl - fshr(longint'(knobs.smooth_pole) * f, 24), 40);
        k = fshr(f, 16);
        frac = f - k * 65536;
        km = ((k % DELAY_DEPTH) + DELAY_DEPTH) % DELAY_DEPTH;
        i0 = int'((wr_ptr + km) % DELAY_DEPTH);
        i1 = (i0 + 1) % DELAY_DEPTH;
        x0 = line_mem[ln][i0];
        x1 = line_mem[ln][i1];
        y = clip(fshr((65536 - frac) * (x0 - last_wet[ln]), 16) + x1, 24);
        last_wet[ln] = y;
        line_mem[ln][wr_ptr] =
            24'(clip(smp - fshr(y * longint'(knobs.feedback_gain), 15), 24));
        wet = longint'(knobs.wet_gain);
        return clip(fshr(y * wet + smp * (65536 - wet), 16), 24);
    endfunction

    function automatic out_item_t predict_frame(in_item_t fr);
        out_item_t o;
        o.left_out = 24'(lane_sample(0, longint'(fr.left_in)));
        o.right_out = 24'(lane_sample(1, longint'(fr.right_in)));
        wr_ptr = (wr_ptr == 0) ? DELAY_DEPTH - 1 : wr_ptr - 1;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch @%0t frame %0d %s: got %0d expected %0d",
                 $realtime, checked_frames, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        for (int i = 0; i < SINE_TABLE_SIZE; i++)
            sine_lut[i] = taylor_sine(32'((64'(i) << 32) / SINE_TABLE_SIZE));
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int l = 0; l < 2; l++)
            begin
                for (int i = 0; i < DELAY_DEPTH; i++)
                    line_mem[l][i] = '0;
                smooth_mem[l] = 0;
                last_wet[l] = 0;
            end
            phase_acc[0] = PHASE_START;
            phase_acc[1] = PHASE_START + QUARTER_TURN;
            wr_ptr = DELAY_DEPTH - 1;
            knobs = '{min_delay: 20'd86016, max_delay: 20'd245760,
                      phase_step: 24'd49169, feedback_gain: 16'sd0,
                      wet_gain: 17'd32768, smooth_gain: 25'd43806,
                      smooth_pole: -26'sd16689606};
            mix_queue.delete();
            fail_count = 0;
            checked_frames = 0;
        end
        else
        begin
            // Take the output side first; a frame accepted now cannot emerge now.
            if (out_valid && out_ready)
            begin
                if (mix_queue.size() == 0)
                begin
                    report_mismatch("unexpected frame", 0, 0);
                end
                else
                begin
                    want = mix_queue.pop_front();
                    if (out_data.left_out !== want.left_out)
                        report_mismatch("left_out", out_data.left_out, want.left_out);
                    if (out_data.right_out !== want.right_out)
                        report_mismatch("right_out", out_data.right_out,
                                        want.right_out);
                end
                checked_frames++;
            end
            if (in_valid && in_ready)
                mix_queue.push_back(predict_frame(in_data));
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_MIN_DELAY:  knobs.min_delay = cfg_data[19:0];
                    REG_MAX_DELAY:  knobs.max_delay = cfg_data[19:0];
                    REG_PHASE_STEP: knobs.phase_step = cfg_data[23:0];
                    REG_FEEDBACK:   knobs.feedback_gain = cfg_data[15:0];
                    REG_WET:        knobs.wet_gain = cfg_data[16:0];
                    REG_SMOOTH_B0:  knobs.smooth_gain = cfg_data[24:0];
                    REG_SMOOTH_A1:  knobs.smooth_pole = cfg_data[25:0];
                    default: ;
                endcase
            end
        end
        pending_frames = mix_queue.size();
    end
endmodule
`default_nettype wire

// ===== tb/lfo_modulated_delay_tb.sv =====
// Testbench top for lfo_modulated_delay: clock, reset, frame and config
// stimulus, verdict. Depends on lfo_md_pkg and lfo_modulated_delay_checker.
`default_nettype none
module lfo_modulated_delay_tb;
    import lfo_md_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [25:0] cfg_data;
    int         fail_count;
    int         pending_frames;
    int         checked_frames;
    int         sent_frames;
    bit         steady_sink;   // no random stalls on the output side
    bit         hold_sink;     // long output stall to fill the pipe

    lfo_modulated_delay DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lfo_modulated_delay_checker CHK (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_frames(pending_frames),
        .checked_frames(checked_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop: the line clear plus ~600 frames at worst-case stalls fit well inside.
    initial
    begin
        #6000000;
        $display("timeout with %0d frames outstanding", pending_frames);
        $display("FAIL lfo_modulated_delay");
        $finish;
    end

    // Output side: random stalls of about 9 in 100, except in steady stretches;
    // the hold request drops ready entirely.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_sink && (steady_sink || $urandom_range(99) >= 9);
    end

    // Offer one frame and hold it until the transfer; valid stays up for the
    // next frame and drops on an idle gap or when the stream drains.
    task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, bit gaps);
        if (gaps && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 9)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{left_in: l, right_in: r};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_frames++;
    endtask

    // Drain all expected frames, then let the pipe settle past its latency.
    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_frames != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [25:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random content with a bias toward full scale so the saturation paths fire.
    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_knobs();
        int sel;
        sel = $urandom_range(2);
        write_reg(REG_MIN_DELAY, sel == 0 ? 26'd0 : 26'($urandom_range(20'hFFFFF)));
        write_reg(REG_MAX_DELAY, sel == 1 ? 26'hFFFFF : 26'($urandom_range(20'hFFFFF)));
        write_reg(REG_PHASE_STEP, 26'($urandom_range(24'hFFFFFF)));
        write_reg(REG_FEEDBACK, 26'(16'($signed($urandom_range(58982)) - 29491)));
        write_reg(REG_WET, 26'($urandom_range(65536)));
        write_reg(REG_SMOOTH_B0, 26'($urandom_range(25'h1000000)));
        write_reg(REG_SMOOTH_A1,
                  26'(26'($signed($urandom_range(33554432)) - 16777216)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_MIN_DELAY;
        cfg_data = '0;
        steady_sink = 1'b1;
        hold_sink = 1'b0;
        sent_frames = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset knobs, full-scale and zero frames, no stalls.
        send_frame(24'sh7FFFFF, 24'sh800000, 0);
        send_frame(24'sh800000, 24'sh7FFFFF, 0);
        send_frame(24'sd0, 24'sd0, 0);
        send_frame(-24'sd1, 24'sd1, 0);
        wait_idle();

        // Extreme knobs: inverted span, full wet, max feedback, fast LFO, b0 of 256, a1 of 1.0.
        write_reg(REG_MIN_DELAY, 26'hFFFFF);
        write_reg(REG_MAX_DELAY, 26'd0);
        write_reg(REG_PHASE_STEP, 26'hFFFFFF);
        write_reg(REG_FEEDBACK, 26'(-16'sd29491));
        write_reg(REG_WET, 26'd65536);
        write_reg(REG_SMOOTH_B0, 26'h1000000);
        write_reg(REG_SMOOTH_A1, 26'h1000000);
        for (int i = 0; i < 8; i++)
            send_frame(i[0] ? 24'sh7FFFFF : 24'sh800000, rand_sample(), 0);
        wait_idle();

        // Other corners: zero span, dry only, positive feedback, negative pole limit.
        write_reg(REG_MIN_DELAY, 26'd0);
        write_reg(REG_PHASE_STEP, 26'd0);
        write_reg(REG_FEEDBACK, 26'd29491);
        write_reg(REG_WET, 26'd0);
        write_reg(REG_SMOOTH_B0, 26'd0);
        write_reg(REG_SMOOTH_A1, 26'(-26'sd16777216));
        for (int i = 0; i < 6; i++)
            send_frame(rand_sample(), rand_sample(), 0);
        wait_idle();

        // Fill test: hold the output off while the sender keeps offering frames.
        steady_sink = 1'b0;
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_frame(rand_sample(), rand_sample(), 0);
        join
        wait_idle();

        // Random phases: fresh knob settings each phase, random gaps on both sides but in phase 3.
        for (int ph = 0; ph < 10; ph++)
        begin
            random_knobs();
            steady_sink = (ph == 3);
            for (int i = 0; i < 52; i++)
                send_frame(rand_sample(), rand_sample(), ph != 3);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d frames across 13 knob settings, incl. extreme knobs", sent_frames);
        $display("and a long output stall; %0d output frames compared", checked_frames);
        if (fail_count == 0 && pending_frames == 0)
            $display("PASS lfo_modulated_delay");
        else
            $display("FAIL lfo_modulated_delay");
        $finish;
    end
endmodule
`default_nettype wire

// ===== lfo_modulated_delay.f =====
sv/lfo_md_pkg.sv
sv/lfo_md_lane.sv
sv/lfo_modulated_delay.sv
tb/lfo_modulated_delay_checker.sv
tb/lfo_modulated_delay_tb.sv
